@@ hw/rtl/bcw_pkg.sv @@
// ----------------------------------------------------------------------------
// bcw_pkg
// Shared types and constants for the blit clip window block.
// ----------------------------------------------------------------------------
package bcw_pkg;

    localparam int unsigned IN_TDATA_W  = 112;
    localparam int unsigned OUT_TDATA_W = 128;

    localparam logic [13:0] FRAME_WIDTH_RST  = 14'd240;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd320;

    typedef enum logic [1:0] {
        CFG_FRAME_BASE   = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } bcw_cfg_idx_t;

    // one draw request
    typedef struct packed {
        logic               cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [13:0]        item_width;
        logic [14:0]        item_height;
        logic [31:0]        sprite_base;
        logic [13:0]        sprite_pad;
    } bcw_item_t;

    // clipped geometry, before address arithmetic
    typedef struct packed {
        logic        visible;
        logic        sprite;
        logic [13:0] col;
        logic [15:0] row;
        logic [15:0] line_count;
        logic [13:0] line_pixels;
        logic [13:0] target_skip;
        logic [14:0] source_skip;
        logic [15:0] src_dx;
        logic [15:0] src_dy;
        logic [14:0] stride;
        logic [31:0] sprite_base;
    } bcw_clip_t;

    // one result
    typedef struct packed {
        logic        visible;
        logic [31:0] target_addr;
        logic [15:0] line_count;
        logic [13:0] line_pixels;
        logic [13:0] target_skip;
        logic [31:0] source_addr;
        logic [14:0] source_skip;
    } bcw_result_t;

endpackage

@@ hw/rtl/bcw_clip.sv @@
// ----------------------------------------------------------------------------
// bcw_clip
// Visibility test and clipping of one request against the frame.
// ----------------------------------------------------------------------------
module bcw_clip
    import bcw_pkg::*;
(
    input  bcw_item_t   item,
    input  logic [13:0] frame_width,
    input  logic [15:0] frame_height,
    output bcw_clip_t   clip
);

    logic signed [16:0] px_s, py_s, w_s, h_s, xend_s, yend_s;
    logic               px_neg, py_neg;
    logic [13:0]        sx1, lp;
    logic [14:0]        sy1;
    logic [14:0]        xsum;
    logic [16:0]        ysum;
    logic [15:0]        lc, col16, row16;
    logic [14:0]        stride;

    always_comb begin
        px_s   = 17'(item.pos_x);
        py_s   = 17'(item.pos_y);
        w_s    = $signed({3'b000, frame_width});
        h_s    = $signed({1'b0, frame_height});
        xend_s = px_s + $signed({3'b000, item.item_width});
        yend_s = py_s + $signed({2'b00, item.item_height});
        px_neg = item.pos_x[15];
        py_neg = item.pos_y[15];

        // negative position: move to 0, shrink size
        col16 = px_neg ? 16'd0 : item.pos_x;
        row16 = py_neg ? 16'd0 : item.pos_y;
        sx1   = px_neg ? xend_s[13:0] : item.item_width;
        sy1   = py_neg ? yend_s[14:0] : item.item_height;

        // trim past right / bottom edge
        xsum = {1'b0, col16[13:0]} + {1'b0, sx1};
        lp   = (xsum > {1'b0, frame_width}) ? 14'(frame_width - col16[13:0]) : sx1;
        ysum = {1'b0, row16} + {2'b00, sy1};
        lc   = (ysum > {1'b0, frame_height}) ? 16'(frame_height - row16) : {1'b0, sy1};

        stride = {1'b0, item.sprite_pad} + {1'b0, item.item_width};

        clip.visible     = (px_s < w_s) && (py_s < h_s) && !xend_s[16] && !yend_s[16];
        clip.sprite      = item.cmd;
        clip.col         = col16[13:0];
        clip.row         = row16;
        clip.line_count  = lc;
        clip.line_pixels = lp;
        clip.target_skip = 14'(frame_width - lp);
        clip.source_skip = 15'(stride - {1'b0, lp});
        clip.src_dx      = px_neg ? 16'(-item.pos_x) : 16'd0;
        clip.src_dy      = py_neg ? 16'(-item.pos_y) : 16'd0;
        clip.stride      = stride;
        clip.sprite_base = item.sprite_base;
    end

endmodule

@@ hw/rtl/bcw_addr.sv @@
// ----------------------------------------------------------------------------
// bcw_addr
// Target and source byte addresses; zeroes fields per visibility and mode.
// ----------------------------------------------------------------------------
module bcw_addr
    import bcw_pkg::*;
#(
    parameter int BYTES_PER_PIXEL = 2
) (
    input  bcw_clip_t   clip,
    input  logic [31:0] frame_base,
    input  logic [13:0] frame_width,
    output bcw_result_t res
);

    logic [29:0] trow;
    logic [30:0] srow;
    logic [31:0] tpix, spix, taddr, saddr;
    logic        src_on;

    always_comb begin
        trow  = {14'd0, clip.row} * {16'd0, frame_width};
        srow  = {15'd0, clip.src_dy} * {16'd0, clip.stride};
        tpix  = {2'b00, trow} + {18'd0, clip.col};
        spix  = {1'b0, srow} + {16'd0, clip.src_dx};
        taddr = frame_base + 32'(tpix * 32'(BYTES_PER_PIXEL));
        saddr = clip.sprite_base + 32'(spix * 32'(BYTES_PER_PIXEL));

        src_on = clip.visible && clip.sprite;

        res.visible     = clip.visible;
        res.target_addr = clip.visible ? taddr : '0;
        res.line_count  = clip.visible ? clip.line_count : '0;
        res.line_pixels = clip.visible ? clip.line_pixels : '0;
        res.target_skip = clip.visible ? clip.target_skip : '0;
        res.source_addr = src_on ? saddr : '0;
        res.source_skip = src_on ? clip.source_skip : '0;
    end

endmodule

@@ hw/rtl/blit_clip_window.sv @@
// ----------------------------------------------------------------------------
// blit_clip_window
// Clipping setup for rectangle fills and sprite copies into a frame buffer.
// ----------------------------------------------------------------------------
// Each request on the s_ stream places a rectangle (tuser 0) or sprite
// (tuser 1) at a signed position against a frame of frame_width x
// frame_height 16-bit-wide pixel slots at byte address frame_base. One
// result comes out on the m_ stream per request, in order. A request is
// visible if it overlaps or exactly touches the frame; it is then clipped
// (negative positions moved to 0, overflow past right/bottom trimmed) and
// the block gives the target byte address, line count, pixels per line and
// target line skip, plus source address and skip in sprite mode. Fields not
// applicable are zero; an invisible request gives an all-zero result.
// Throughput: one transaction per cycle while m_tready is high. A request
// passes the input register, the clip register and the result register
// before m_tvalid, and the row-times-width multiply and base add sit
// between the last two. Each register stage holds while the
// next one is full and stalled, so back-pressure on m_tready ripples to
// s_tready without dropping anything. The configuration registers are
// written through the cfg_ channel (always ready) and must only change
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module blit_clip_window
    import bcw_pkg::*;
#(
    parameter int BYTES_PER_PIXEL = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pos_x[15:0] pos_y[31:16] item_width[45:32] item_height[60:46]
    // sprite_base[92:61] sprite_pad[106:93], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic                   s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // target_addr[31:0] line_count[47:32] line_pixels[61:48]
    // target_skip[75:62] source_addr[107:76] source_skip[122:108], zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // visible
    output logic                   m_tuser,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);

    // configuration registers
    logic [31:0] frame_base_reg;
    logic [13:0] frame_width_reg;
    logic [15:0] frame_height_reg;

    // pipeline registers
    logic        s1_valid_reg, s2_valid_reg, m_valid_reg;
    bcw_item_t   s1_item_reg,  s1_item_next;
    bcw_clip_t   s2_clip_reg,  s2_clip_next;
    bcw_result_t m_res_reg,    m_res_next;

    logic out_free, s2_free, s1_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg   <= '0;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FRAME_BASE:   frame_base_reg   <= cfg_data;
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[13:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[15:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // a stage may take new data when empty or when its contents move on
    assign out_free = !m_valid_reg || m_tready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_tready = s1_free;

    // unpack the incoming transaction
    always_comb begin
        s1_item_next.cmd         = s_tuser;
        s1_item_next.pos_x       = s_tdata[15:0];
        s1_item_next.pos_y       = s_tdata[31:16];
        s1_item_next.item_width  = s_tdata[45:32];
        s1_item_next.item_height = s_tdata[60:46];
        s1_item_next.sprite_base = s_tdata[92:61];
        s1_item_next.sprite_pad  = s_tdata[106:93];
    end

    bcw_clip u_clip (
        .item         (s1_item_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .clip         (s2_clip_next)
    );

    bcw_addr #(
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
    ) u_addr (
        .clip        (s2_clip_reg),
        .frame_base  (frame_base_reg),
        .frame_width (frame_width_reg),
        .res         (m_res_next)
    );

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_free)  s1_valid_reg <= s_tvalid;
            if (s2_free)  s2_valid_reg <= s1_valid_reg;
            if (out_free) m_valid_reg  <= s2_valid_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s1_free && s_tvalid)      s1_item_reg <= s1_item_next;
        if (s2_free && s1_valid_reg)  s2_clip_reg <= s2_clip_next;
        if (out_free && s2_valid_reg) m_res_reg   <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.visible;
    assign m_tdata  = {5'd0,
                       m_res_reg.source_skip,
                       m_res_reg.source_addr,
                       m_res_reg.target_skip,
                       m_res_reg.line_pixels,
                       m_res_reg.line_count,
                       m_res_reg.target_addr};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled with a bubble in the pipeline");

    a_hidden_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("invisible request with non-zero result");

    a_pixels_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            ({1'b0, m_res_reg.line_pixels} + {1'b0, m_res_reg.target_skip}
             == {1'b0, frame_width_reg}))
        else $error("clipped width and target skip do not add to frame width");

    a_lines_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_res_reg.line_count <= frame_height_reg))
        else $error("clipped line count exceeds frame height");

endmodule

@@ tb/blit_clip_window_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_clip_window_checker
// Watches the request, result and register channels of the clip block,
// works out the clipped geometry of every accepted request and compares it
// field by field with the result stream, in order.
// ----------------------------------------------------------------------------
module blit_clip_window_checker
    import bcw_pkg::*;
#(
    parameter int BYTES_PER_PIXEL = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     clips_due,
    output int                     mismatches
);

    logic [31:0] frame_base_q;
    logic [13:0] frame_width_q;
    logic [15:0] frame_height_q;

    bcw_result_t clips_expected[$];
    int          result_no;

    initial begin
        clips_due  = 0;
        mismatches = 0;
        result_no  = 0;
    end

    // Clip one request against the current frame; wide signed maths throughout.
    function automatic bcw_result_t clip_request(bcw_item_t req);
        longint      x0, y0, x, y, sx, sy, w, h, stride, tpix, spix;
        bcw_result_t r;
        r  = '0;
        w  = longint'(frame_width_q);
        h  = longint'(frame_height_q);
        x0 = $signed(req.pos_x);
        y0 = $signed(req.pos_y);
        sx = longint'(req.item_width);
        sy = longint'(req.item_height);
        x  = x0;
        y  = y0;
        if (!(x < w && y < h && x + sx >= 0 && y + sy >= 0))
            return r;
        if (x < 0) begin
            sx = sx + x;
            x  = 0;
        end
        if (y < 0) begin
            sy = sy + y;
            y  = 0;
        end
        if (x + sx > w)
            sx = w - x;
        if (y + sy > h)
            sy = h - y;
        tpix          = x + y * w;
        r.visible     = 1'b1;
        r.target_addr = 32'(longint'(frame_base_q) + tpix * BYTES_PER_PIXEL);
        r.line_count  = 16'(sy);
        r.line_pixels = 14'(sx);
        r.target_skip = 14'(w - sx);
        if (req.cmd) begin
            stride        = longint'(req.sprite_pad) + longint'(req.item_width);
            spix          = (x - x0) + (y - y0) * stride;
            r.source_addr = 32'(longint'(req.sprite_base) + spix * BYTES_PER_PIXEL);
            r.source_skip = 15'(stride - sx);
        end
        return r;
    endfunction

    task automatic log_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch %0d: %s", $time, mismatches, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                   result_no, name, got, want));
    endtask

    always @(posedge aclk) begin : watch
        bcw_item_t   req;
        bcw_result_t got;
        bcw_result_t want;
        if (!aresetn) begin
            frame_base_q   <= '0;
            frame_width_q  <= FRAME_WIDTH_RST;
            frame_height_q <= FRAME_HEIGHT_RST;
            clips_expected.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_BASE:   frame_base_q   <= cfg_data;
                    CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[13:0];
                    CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[15:0];
                    default: ;
                endcase
            end
            // results first, so a stray result is never paired with a fresh request
            if (m_tvalid && m_tready) begin
                got.visible     = m_tuser;
                got.target_addr = m_tdata[31:0];
                got.line_count  = m_tdata[47:32];
                got.line_pixels = m_tdata[61:48];
                got.target_skip = m_tdata[75:62];
                got.source_addr = m_tdata[107:76];
                got.source_skip = m_tdata[122:108];
                if (clips_expected.size() == 0) begin
                    log_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                           result_no));
                end else begin
                    want = clips_expected.pop_front();
                    check_field("visible", 32'(got.visible), 32'(want.visible));
                    check_field("target_addr", got.target_addr, want.target_addr);
                    check_field("line_count", 32'(got.line_count), 32'(want.line_count));
                    check_field("line_pixels", 32'(got.line_pixels), 32'(want.line_pixels));
                    check_field("target_skip", 32'(got.target_skip), 32'(want.target_skip));
                    check_field("source_addr", got.source_addr, want.source_addr);
                    check_field("source_skip", 32'(got.source_skip), 32'(want.source_skip));
                end
                result_no++;
            end
            if (s_tvalid && s_tready) begin
                req.cmd         = s_tuser;
                req.pos_x       = s_tdata[15:0];
                req.pos_y       = s_tdata[31:16];
                req.item_width  = s_tdata[45:32];
                req.item_height = s_tdata[60:46];
                req.sprite_base = s_tdata[92:61];
                req.sprite_pad  = s_tdata[106:93];
                clips_expected.push_back(clip_request(req));
            end
        end
        clips_due <= clips_expected.size();
    end

endmodule

@@ tb/tb_blit_clip_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blit_clip_window
// Self-checking bench for the blit clip window block: drives draw requests
// and frame register settings, with random idle gaps on both streams, while
// a separate checker predicts every result and compares it.
// ----------------------------------------------------------------------------
module tb_blit_clip_window
    import bcw_pkg::*;
();

    localparam int BPP             = 2;
    localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles before giving up
    localparam int DRAIN_CYCLES    = 12;    // margin after the last outstanding result
    localparam int HOLD_OFF_CYCLES = 120;   // long sink stall to back up the pipe
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 205;
    localparam int PRESSURE_PHASE  = 5;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // pos_x, pos_y, item_width, item_height, sprite_base, sprite_pad (lsb up)
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    // cmd
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // target_addr, line_count, line_pixels, target_skip, source_addr,
    // source_skip (lsb up)
    logic [OUT_TDATA_W-1:0] m_tdata;
    // visible
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = CFG_FRAME_BASE;
    logic [31:0]            cfg_data  = '0;

    int clips_due;
    int mismatches;

    // stimulus bookkeeping
    int requests_sent = 0;
    int results_seen  = 0;
    int visible_seen  = 0;
    int quiet_cycles  = 0;
    int cur_w         = FRAME_WIDTH_RST;
    int cur_h         = FRAME_HEIGHT_RST;
    bit src_idle      = 1'b1;
    bit sink_idle     = 1'b1;
    bit hold_off_req  = 1'b0;

    always #5 aclk = ~aclk;

    blit_clip_window #(
        .BYTES_PER_PIXEL(BPP)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    blit_clip_window_checker #(
        .BYTES_PER_PIXEL(BPP)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .clips_due  (clips_due),
        .mismatches (mismatches)
    );

    // Builds one draw request from plain integers; fields truncate to width.
    function automatic bcw_item_t draw_req(bit sprite, int x, int y, int w, int h,
                                           logic [31:0] base, int pad);
        bcw_item_t r;
        r.cmd         = sprite;
        r.pos_x       = 16'(x);
        r.pos_y       = 16'(y);
        r.item_width  = 14'(w);
        r.item_height = 15'(h);
        r.sprite_base = base;
        r.sprite_pad  = 14'(pad);
        return r;
    endfunction

    // Position along one axis: mostly around the frame so that clipping
    // actually happens, some exactly on the visibility boundary, the rest
    // anywhere in the 16-bit signed range.
    function automatic int pick_pos(int span, int size);
        int p;
        case ($urandom_range(0, 9))
            0, 1: p = int'($urandom_range(0, 65535)) - 32768;
            2: begin
                case ($urandom_range(0, 3))
                    0:       p = span;
                    1:       p = span - 1;
                    2:       p = -size;
                    default: p = -size - 1;
                endcase
            end
            default: p = int'($urandom_range(0, span + size + 8)) - size - 4;
        endcase
        if (p < -32768)
            p = -32768;
        if (p > 32767)
            p = 32767;
        return p;
    endfunction

    function automatic bcw_item_t make_request(int w, int h);
        int sw, sh;
        case ($urandom_range(0, 3))
            0:       sw = $urandom_range(0, 8);
            1:       sw = $urandom_range(0, (w + 16 > 16383) ? 16383 : w + 16);
            2:       sw = $urandom_range(0, 16383);
            default: sw = w;
        endcase
        case ($urandom_range(0, 3))
            0:       sh = $urandom_range(0, 8);
            1:       sh = $urandom_range(0, (h + 16 > 32767) ? 32767 : h + 16);
            2:       sh = $urandom_range(0, 32767);
            default: sh = (h > 32767) ? 32767 : h;
        endcase
        // pad is usually small, sometimes anything in 14 bits
        return draw_req($urandom_range(0, 1), pick_pos(w, sw), pick_pos(h, sh), sw, sh,
                        $urandom,
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                    : $urandom_range(0, 15));
    endfunction

    // One request transaction. tvalid stays high between back-to-back
    // requests and only drops when a gap is drawn.
    task automatic send_request(input bcw_item_t req);
        int                    gap;
        logic [IN_TDATA_W-1:0] word;
        gap  = src_idle ? $urandom_range(0, 11) : 0;
        word = '0;
        word[106:0] = {req.sprite_pad, req.sprite_base, req.item_height,
                       req.item_width, req.pos_y, req.pos_x};
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= req.cmd;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Stop offering requests and let every outstanding result come out.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (clips_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register transaction; cfg_valid is left high for the caller.
    task automatic cfg_write(input bcw_cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // New frame geometry, only ever with the pipeline empty.
    task automatic set_frame(input logic [31:0] base, input int w, input int h);
        drain_pipeline();
        cfg_write(CFG_FRAME_BASE, base);
        cfg_write(CFG_FRAME_WIDTH, 32'(w));
        cfg_write(CFG_FRAME_HEIGHT, 32'(h));
        cfg_valid <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random ready gaps per result, plus one long hold-off when
    // the stimulus asks for it, so the block fills and stalls s_tready.
    // ------------------------------------------------------------------------
    initial begin : sink
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            gap = sink_idle ? $urandom_range(0, 11) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog and run statistics. Any transaction on any channel counts as
    // progress.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (m_tuser)
                visible_seen <= visible_seen + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, clips_due);
            $display("blit_clip_window test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] base;
        int          fw, fh;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests against the reset frame: 240 x 320 at address 0.
        send_request(draw_req(0, 10, 20, 30, 40, 32'h0, 0));
        send_request(draw_req(1, 5, 6, 7, 8, 32'h1000_0000, 3));
        send_request(draw_req(1, -5, 10, 20, 4, 32'h0000_4000, 0));      // left clip
        send_request(draw_req(1, 10, -7, 12, 20, 32'hFFFF_FFF0, 16383)); // top clip, wrap
        send_request(draw_req(1, -100, -200, 300, 400, 32'h8000_0000, 7));
        send_request(draw_req(0, 240, 0, 5, 5, 32'h0, 0));               // starts past right
        send_request(draw_req(0, 239, 0, 5, 5, 32'h0, 0));               // last column
        send_request(draw_req(1, -10, 5, 10, 3, 32'h1234_5678, 2));      // ends on column 0
        send_request(draw_req(1, -11, 5, 10, 3, 32'h1234_5678, 2));      // one short of it
        send_request(draw_req(0, 0, 320, 4, 4, 32'h0, 0));               // starts past bottom
        send_request(draw_req(0, 0, 319, 4, 4, 32'h0, 0));
        send_request(draw_req(1, 3, -4, 2, 4, 32'hABCD_0000, 1));        // ends on line 0
        send_request(draw_req(1, 200, 300, 100, 100, 32'h0000_2000, 9)); // right/bottom trim
        send_request(draw_req(1, -32768, -32768, 16383, 32767, 32'hFFFF_FFFF, 16383));
        send_request(draw_req(0, 32767, 32767, 16383, 32767, 32'hFFFF_FFFF, 16383));
        send_request(draw_req(1, -16383, -32767, 16383, 32767, 32'hFFFF_FFFF, 16383));
        send_request(draw_req(0, 0, 0, 0, 0, 32'h0, 0));
        send_request(draw_req(1, 239, 319, 0, 0, 32'h5555_5555, 0));
        send_request(draw_req(1, -100, -100, 16383, 32767, 32'hFFFF_FFFF, 16383));

        // Largest frame right at the top of the address space.
        set_frame(32'hFFFF_FFFF, 16383, 65535);
        send_request(draw_req(1, 16382, 32767, 16383, 32767, 32'hFFFF_FFFF, 16383));
        send_request(draw_req(0, 0, 0, 16383, 32767, 32'h0, 0));
        send_request(draw_req(1, -1, -1, 16383, 32767, 32'hFFFF_FFFE, 16383));

        // Single-pixel frame.
        set_frame(32'h0, 1, 1);
        send_request(draw_req(0, 0, 0, 1, 1, 32'h0, 0));
        send_request(draw_req(1, -1, -1, 1, 1, 32'hFFFF_FFFF, 16383));
        send_request(draw_req(1, 1, 0, 1, 1, 32'h0, 0));

        // Random phases, each under its own frame geometry.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            base = $urandom;
            case (phase)
                0: begin fw = 240;  fh = 320;   end
                1: begin base = 32'hFFFF_FFFF; fw = 16383; fh = 65535; end
                2: begin fw = 1;    fh = 1;     end
                3: begin fw = $urandom_range(1, 16383); fh = $urandom_range(1, 65535); end
                4: begin fw = $urandom_range(16, 64);   fh = $urandom_range(16, 64);   end
                5: begin base = 32'h0; fw = 640; fh = 480; end
                6: begin fw = 1;    fh = 65535; end
                default: begin fw = 16383; fh = 1; end
            endcase
            set_frame(base, fw, fh);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // re-draw the idle pattern now and then; about a quarter of
                // the stretches run flat out on each side
                if (i % 40 == 0) begin
                    src_idle  = ($urandom_range(0, 3) != 0);
                    sink_idle = ($urandom_range(0, 3) != 0);
                end
                if (phase == PRESSURE_PHASE && i == 20) begin
                    // sink stops for a long while; keep offering requests
                    src_idle     = 1'b0;
                    hold_off_req = 1'b1;
                end
                send_request(make_request(cur_w, cur_h));
            end
        end

        drain_pipeline();

        $display("%0d draw requests over %0d frame settings, %0d results (%0d visible)",
                 requests_sent, NUM_PHASES + 3, results_seen, visible_seen);
        $display("covered edge touching, negative origins, overflow trims, address wrap");
        if (mismatches == 0) begin
            $display("blit_clip_window test passed");
        end else begin
            $display("blit_clip_window test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bcw_pkg.sv
hw/rtl/bcw_clip.sv
hw/rtl/bcw_addr.sv
hw/rtl/blit_clip_window.sv
tb/blit_clip_window_checker.sv
tb/tb_blit_clip_window.sv
